@@ hw/rtl/cgb_pkg.sv @@
// ----------------------------------------------------------------------------
// cgb_pkg
// Shared types and constants of the CSR graph builder.
// ----------------------------------------------------------------------------
package cgb_pkg;

   localparam int NODE_W = 10;
   localparam int SLOT_W = 12;
   localparam int CNT_W  = 13;
   localparam int NCNT_W = 11;

   localparam logic [1:0] REQ_APPEND   = 2'd0;
   localparam logic [1:0] REQ_FINALIZE = 2'd1;
   localparam logic [1:0] REQ_RANGE    = 2'd2;
   localparam logic [1:0] REQ_SLOT     = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_DROPPED = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [NODE_W-1:0] source_node;
      logic              source_valid;
      logic [NODE_W-1:0] target_node;
      logic              target_valid;
      logic [NODE_W-1:0] query_node;
      logic [SLOT_W-1:0] slot_position;
   } req_type_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [CNT_W-1:0]  range_start;
      logic [CNT_W-1:0]  range_end;
      logic [NODE_W-1:0] slot_target;
      logic [SLOT_W-1:0] slot_edge_id;
      logic [NCNT_W-1:0] node_count;
      logic [CNT_W-1:0]  edge_count;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOKUP,
      S_CLR,
      S_CNT,
      S_CNT_WB,
      S_PFX,
      S_PFX_WB,
      S_SCT,
      S_SCT_WB,
      S_DONE
   } state_type;

endpackage

@@ hw/rtl/cgb_ram.sv @@
// ----------------------------------------------------------------------------
// cgb_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module cgb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ hw/rtl/csr_graph_builder.sv @@
// ----------------------------------------------------------------------------
// csr_graph_builder
// Builds a compressed sparse row index from appended edges; answers lookups.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; its single
// response appears for one cycle with rsp_valid set and cannot be stalled.
// Append answers straight from idle; range and slot lookups pass through the
// lookup state for one memory read. Finalize walks the stores on single-port
// memories: clear the degree table, count the degrees of loaded rows with both
// ends valid, build the offsets of each node, then scatter those rows.
// Busy stays high for that whole walk. The reverse_direction register is
// sampled during finalize; the user must write it only while the block is
// idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module csr_graph_builder
   import cgb_pkg::*;
#(
   parameter int MAX_NODES = 1024,
   parameter int MAX_EDGES = 4096
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_type_type req_data,
   output logic         rsp_valid,
   output rsp_type      rsp_data,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data
);
   localparam int EA_W = $clog2(MAX_EDGES);
   localparam int NA_W = $clog2(MAX_NODES);
   localparam int OA_W = $clog2(MAX_NODES + 1);

   // config
   logic reverse_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         reverse_ff <= 1'b0;
      end else if (csr_wr_en) begin
         reverse_ff <= csr_wr_data;
      end
   end

   // control state
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  edges_ff, edges_in;
   logic [NODE_W-1:0] largest_ff, largest_in;
   logic [NCNT_W-1:0] nodes_ff, nodes_in;
   logic              ready_ff, ready_in;
   logic [CNT_W-1:0]  total_ff, total_in;     // offset_store[nodes_built]
   logic [CNT_W-1:0]  idx_ff, idx_in;         // walk index
   logic [CNT_W-1:0]  sum_ff, sum_in;
   req_type_type      req_ff, req_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   // Second phase of count / scatter: the row read issued in the walk state
   // lands in the write-back state, which reads the degree table; that read
   // lands in the cycle after and is written back from the stage below.
   logic              wb2_ff, wb2_in;
   logic              wb2_sct_ff, wb2_sct_in;
   logic [NODE_W-1:0] wb2_s_ff, wb2_s_in, wb2_t_ff, wb2_t_in;
   logic [SLOT_W-1:0] wb2_id_ff, wb2_id_in;

   // memory ports
   logic              e_we;
   logic [EA_W-1:0]   e_addr;
   logic [NODE_W-1:0] es_wd, es_rd, et_wd, et_rd;
   logic [1:0]        ev_wd, ev_rd;
   logic              d_we;
   logic [NA_W-1:0]   d_addr;
   logic [CNT_W-1:0]  d_wd, d_rd;
   logic              o_we;
   logic [OA_W-1:0]   o_addr;
   logic [CNT_W-1:0]  o_wd, o_rd;
   logic [EA_W-1:0]   a_addr;
   logic [NODE_W-1:0] at_rd;
   logic [SLOT_W-1:0] ae_rd;
   logic              o2_we;
   logic [NA_W-1:0]   o2_addr;
   logic [CNT_W-1:0]  o2_wd, o2_rd;  // end offsets: offset_store[k+1]

   // final port drive with write-back overrides
   logic              fd_we, fa_we;
   logic [NA_W-1:0]   fd_addr;
   logic [CNT_W-1:0]  fd_wd;
   logic [EA_W-1:0]   fa_addr;

   cgb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_esrc (
      .clock, .wr_en(e_we), .addr(e_addr), .wr_data(es_wd), .rd_data(es_rd));
   cgb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_etgt (
      .clock, .wr_en(e_we), .addr(e_addr), .wr_data(et_wd), .rd_data(et_rd));
   cgb_ram #(.WIDTH(2), .DEPTH(MAX_EDGES)) u_evld (
      .clock, .wr_en(e_we), .addr(e_addr), .wr_data(ev_wd), .rd_data(ev_rd));
   cgb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_deg (
      .clock, .wr_en(fd_we), .addr(fd_addr), .wr_data(fd_wd), .rd_data(d_rd));
   cgb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES + 1)) u_off (
      .clock, .wr_en(o_we), .addr(o_addr), .wr_data(o_wd), .rd_data(o_rd));
   cgb_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_oend (
      .clock, .wr_en(o2_we), .addr(o2_addr), .wr_data(o2_wd), .rd_data(o2_rd));
   cgb_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_atgt (
      .clock, .wr_en(fa_we), .addr(fa_addr), .wr_data(wb2_t_ff), .rd_data(at_rd));
   cgb_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_EDGES)) u_aid (
      .clock, .wr_en(fa_we), .addr(fa_addr), .wr_data(wb2_id_ff), .rd_data(ae_rd));

   logic accept;
   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // edge row seen from the build direction
   logic [NODE_W-1:0] row_s, row_t;
   assign row_s = reverse_ff ? et_rd : es_rd;
   assign row_t = reverse_ff ? es_rd : et_rd;

   function automatic logic [NCNT_W-1:0] nodes_in_final();
      return (edges_ff != '0) ? (NCNT_W'(largest_ff) + NCNT_W'(1)) : '0;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  REQ_FINALIZE: state_in = S_CLR;
                  REQ_RANGE, REQ_SLOT: state_in = S_LOOKUP;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_LOOKUP: state_in = S_IDLE;
         S_CLR:    if (idx_ff == CNT_W'(MAX_NODES - 1)) state_in = S_CNT;
         S_CNT:    state_in = (idx_ff >= edges_ff) ? S_PFX : S_CNT_WB;
         S_CNT_WB: state_in = S_CNT;
         S_PFX:    state_in = (idx_ff >= CNT_W'(nodes_in_final())) ? S_SCT : S_PFX_WB;
         S_PFX_WB: state_in = S_PFX;
         S_SCT:    state_in = (idx_ff >= edges_ff) ? S_DONE : S_SCT_WB;
         S_SCT_WB: state_in = S_SCT;
         S_DONE:   state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   logic        app_drop;
   always_comb begin
      app_drop = (edges_ff >= CNT_W'(MAX_EDGES))
         || (req_data.source_valid && ({1'b0, req_data.source_node} >= (NODE_W+1)'(MAX_NODES)))
         || (req_data.target_valid && ({1'b0, req_data.target_node} >= (NODE_W+1)'(MAX_NODES)));
   end

   always_comb begin
      edges_in     = edges_ff;
      largest_in   = largest_ff;
      nodes_in     = nodes_ff;
      ready_in     = ready_ff;
      total_in     = total_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      req_in       = req_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      e_we   = 1'b0; e_addr = idx_ff[EA_W-1:0];
      es_wd  = req_data.source_node; et_wd = req_data.target_node;
      ev_wd  = {req_data.target_valid, req_data.source_valid};
      d_we   = 1'b0; d_addr = row_s[NA_W-1:0]; d_wd = '0;
      o_we   = 1'b0; o_addr = idx_ff[OA_W-1:0]; o_wd = sum_ff;
      o2_we  = 1'b0; o2_addr = row_s[NA_W-1:0]; o2_wd = '0;
      a_addr = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in = req_data;
               case (req_data.req_type)
                  REQ_APPEND: begin
                     rsp_valid_in = 1'b1;
                     if (app_drop) begin
                        rsp_in.status = ST_DROPPED;
                     end else begin
                        e_we     = 1'b1;
                        e_addr   = edges_ff[EA_W-1:0];
                        edges_in = edges_ff + CNT_W'(1);
                        ready_in = 1'b0;
                        if (req_data.source_valid && req_data.source_node > largest_in)
                           largest_in = req_data.source_node;
                        if (req_data.target_valid && req_data.target_node > largest_in)
                           largest_in = req_data.target_node;
                     end
                     rsp_in.edge_count = edges_in;
                     rsp_in.node_count = nodes_ff;
                  end
                  REQ_FINALIZE: begin
                     idx_in = '0;
                  end
                  REQ_RANGE: begin
                     o_addr  = OA_W'(req_data.query_node);
                     o2_addr = NA_W'(req_data.query_node);
                  end
                  default: begin
                     a_addr = EA_W'(req_data.slot_position);
                  end
               endcase
            end
         end
         S_LOOKUP: begin
            rsp_valid_in      = 1'b1;
            rsp_in.node_count = nodes_ff;
            rsp_in.edge_count = edges_ff;
            if (req_ff.req_type == REQ_RANGE) begin
               if (!ready_ff || NCNT_W'(req_ff.query_node) >= nodes_ff) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  rsp_in.range_start = o_rd;
                  rsp_in.range_end   = o2_rd;
               end
            end else begin
               if (!ready_ff || CNT_W'(req_ff.slot_position) >= total_ff) begin
                  rsp_in.status = ST_RANGE;
               end else begin
                  rsp_in.slot_target  = at_rd;
                  rsp_in.slot_edge_id = ae_rd;
               end
            end
         end
         S_CLR: begin
            d_we   = 1'b1;
            d_addr = idx_ff[NA_W-1:0];
            idx_in = (idx_ff == CNT_W'(MAX_NODES - 1)) ? '0 : idx_ff + CNT_W'(1);
         end
         S_CNT: begin
            // read edge row idx
            e_addr = idx_ff[EA_W-1:0];
            idx_in = idx_ff + CNT_W'(1);
            if (idx_ff >= edges_ff) begin
               idx_in = '0;
               sum_in = '0;
            end
         end
         S_CNT_WB: begin
            // row now on es/et/ev; read its degree, bumped in the next cycle
            e_addr = idx_ff[EA_W-1:0] - EA_W'(1);
            d_addr = row_s[NA_W-1:0];
         end
         S_PFX: begin
            d_addr = idx_ff[NA_W-1:0];
            if (idx_ff >= CNT_W'(nodes_in_final())) begin
               o_we     = 1'b1;
               o_addr   = idx_ff[OA_W-1:0];
               o_wd     = sum_ff;
               total_in = sum_ff;
               idx_in   = '0;
            end
         end
         S_PFX_WB: begin
            // degree of node idx on d_rd; write start and end, and turn the
            // degree entry into the node's fill cursor for the scatter
            d_we    = 1'b1;
            d_addr  = idx_ff[NA_W-1:0];
            d_wd    = sum_ff;
            o_we    = 1'b1;
            o_addr  = idx_ff[OA_W-1:0];
            o_wd    = sum_ff;
            o2_we   = 1'b1;
            o2_addr = idx_ff[NA_W-1:0];
            o2_wd   = sum_ff + d_rd;
            sum_in  = sum_ff + d_rd;
            idx_in  = idx_ff + CNT_W'(1);
         end
         S_SCT: begin
            e_addr = idx_ff[EA_W-1:0];
            idx_in = idx_ff + CNT_W'(1);
         end
         S_SCT_WB: begin
            // read the fill cursor of the row's node
            e_addr = idx_ff[EA_W-1:0] - EA_W'(1);
            d_addr = row_s[NA_W-1:0];
         end
         S_DONE: begin
            nodes_in          = nodes_in_final();
            ready_in          = 1'b1;
            rsp_valid_in      = 1'b1;
            rsp_in.node_count = nodes_in;
            rsp_in.edge_count = edges_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      wb2_in     = ((state_ff == S_CNT_WB) || (state_ff == S_SCT_WB)) && (ev_rd == 2'b11);
      wb2_sct_in = (state_ff == S_SCT_WB);
      wb2_s_in   = row_s;
      wb2_t_in   = row_t;
      wb2_id_in  = SLOT_W'(idx_ff - CNT_W'(1));
   end

   always_ff @(posedge clock) begin
      wb2_s_ff  <= wb2_s_in;
      wb2_t_ff  <= wb2_t_in;
      wb2_id_ff <= wb2_id_in;
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      sum_ff    <= sum_in;
      total_ff  <= total_in;
      idx_ff    <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         edges_ff     <= '0;
         largest_ff   <= '0;
         nodes_ff     <= '0;
         ready_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wb2_ff       <= 1'b0;
         wb2_sct_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         edges_ff     <= edges_in;
         largest_ff   <= largest_in;
         nodes_ff     <= nodes_in;
         ready_ff     <= ready_in;
         rsp_valid_ff <= rsp_valid_in;
         wb2_ff       <= wb2_in;
         wb2_sct_ff   <= wb2_sct_in;
      end
   end

   // The late write-back lands while the walk state issues the next row
   // read; the degree and adjacency ports are free then. Counting bumps the
   // degree; scattering places the row at the node's cursor and advances it,
   // so rows keep arrival order within each node.
   always_comb begin
      fd_we = d_we; fd_addr = d_addr; fd_wd = d_wd;
      fa_we = 1'b0; fa_addr = a_addr;
      if (wb2_ff) begin
         fd_we = 1'b1; fd_addr = wb2_s_ff[NA_W-1:0]; fd_wd = d_rd + CNT_W'(1);
      end
      if (wb2_ff && wb2_sct_ff) begin
         fa_we = 1'b1; fa_addr = d_rd[EA_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_busy_finalize: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.req_type == REQ_FINALIZE |=> busy)
      else $error("finalize did not raise busy");
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && $past(state_ff) == S_CLR |-> 1'b0)
      else $error("response during clear");
   a_edges_cap: assert property (@(posedge clock) disable iff (reset)
      edges_ff <= CNT_W'(MAX_EDGES))
      else $error("edge count beyond capacity");
   a_ready_drop: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.req_type == REQ_APPEND && !app_drop |=> !ready_ff)
      else $error("index still ready after append");
`endif
endmodule
